// File: hw/rtl/tfsd_pkg.sv
// Shared constants, codes and helpers for the track format stream decoder.
// No dependencies.
`default_nettype none

package tfsd_pkg;

   // Default output capacity in bytes
   localparam int unsigned OUT_CAPACITY_DEF = 8192;

   // Mark bytes on the raw track
   localparam logic [7:0] MARK_ID   = 8'hFE;
   localparam logic [7:0] MARK_DATA = 8'hFB;
   localparam logic [7:0] MARK_CRC  = 8'hF7;

   // Sector geometry and gap lengths
   localparam int unsigned BASE_SHIFT     = 7;
   localparam int unsigned SIZE_CODES     = 4;
   localparam int unsigned HDR_TAIL_SKIP  = 10;
   localparam int unsigned DATA_TAIL_SKIP = 14;
   localparam int unsigned CNT_W          = 11;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_SECTOR = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // Track status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_NO_HCRC  = 3'd2,
      ST_NO_DCRC  = 3'd3,
      ST_NO_SPACE = 3'd4
   } status_type;

   // Sector length in bytes for a size code
   function automatic logic [CNT_W-1:0] sector_bytes(input logic [1:0] code);
      logic [CNT_W-1:0] base;
      base = CNT_W'(1) << BASE_SHIFT;
      return base << code;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/track_format_stream_decoder_top.sv
// Track format stream decoder: pulls sector data out of a raw written track.
// Block usage:
//   req_ channel carries one raw track byte per transaction, with
//   req_end_of_track marking the final byte of the track.
//   rsp_ channel carries one result per transaction: a sector data byte with
//   its output offset, a sector-completed record, or the end-of-track status.
//   rsp_last marks the last result caused by one raw byte.
// Timing:
//   A raw byte lands in an input register, is decoded there once the result
//   buffer can take its results, and they are written to a two-entry result
//   buffer at the end of that cycle; results leave from the buffer head.
//   Throughput is one byte per cycle while rsp_stall is low and each byte
//   causes at most one result. A byte that causes two results (a data byte
//   or sector completion on the final byte of the track) holds the next
//   byte in the input register while both wait; the port drains one per cycle.
// Reset clears the decoder to scanning, empties the input register and the
// result buffer. When the receiver raises rsp_stall the buffer holds its
// results and req_stall rises once the input register cannot be decoded.
// Depends on tfsd_pkg.
`default_nettype none

module track_format_stream_decoder_top
   import tfsd_pkg::*;
#(
   parameter int unsigned OUT_CAPACITY = OUT_CAPACITY_DEF,
   localparam int unsigned OFF_W = $clog2(OUT_CAPACITY),
   localparam int unsigned TOT_W = $clog2(OUT_CAPACITY + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // raw byte channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_raw_byte,
   input  wire logic             req_end_of_track,
   // result channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [OFF_W-1:0]      rsp_write_offset,
   output logic [7:0]            rsp_id_track,
   output logic [7:0]            rsp_id_side,
   output logic [7:0]            rsp_id_sector,
   output logic [1:0]            rsp_size_code,
   output logic [6:0]            rsp_sector_count,
   output logic [TOT_W-1:0]      rsp_data_total,
   output logic [2:0]            rsp_status,
   output logic                  rsp_last
);

   typedef enum logic [2:0] {
      PH_SCAN, PH_HEADER, PH_HDR_CRC, PH_SKIP, PH_DATA, PH_DATA_CRC, PH_FROZEN
   } phase_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data;
      logic [OFF_W-1:0] offset;
      logic [7:0]       trk;
      logic [7:0]       side;
      logic [7:0]       sec;
      logic [1:0]       size;
      logic [6:0]       count;
      logic [TOT_W-1:0] total;
      status_type       status;
      logic             last;
   } result_type;

   localparam logic [TOT_W:0] CAP = (TOT_W+1)'(OUT_CAPACITY);

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_eot_ff;

   // decoder state
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       trk_ff, trk_in;
   logic [7:0]       side_ff, side_in;
   logic [7:0]       sec_ff, sec_in;
   logic [1:0]       size_ff, size_in;
   logic [TOT_W-1:0] pos_ff, pos_in;
   logic [6:0]       nsec_ff, nsec_in;
   status_type       err_ff, err_in;
   logic             fits_ff, fits_in;

   // result buffer
   result_type       slot0_ff, slot0_in;
   result_type       slot1_ff, slot1_in;
   logic [1:0]       fill_ff, fill_in;

   logic             pop, load_ok, process, accept;
   logic             has_res;
   kind_type         res_kind;
   logic [7:0]       res_data;
   logic [OFF_W-1:0] res_off;
   logic [CNT_W-1:0] sec_len, cnt_inc;
   logic [TOT_W:0]   fit_sum;
   logic [TOT_W:0]   off_sum;
   result_type       r_first, r_stat;

   // handshakes
   assign pop       = rsp_valid && !rsp_stall;
   assign load_ok   = (fill_ff == 2'd0) || ((fill_ff == 2'd1) && pop);
   assign process   = in_valid_ff && load_ok;
   assign req_stall = in_valid_ff && !load_ok;
   assign accept    = req_valid && !req_stall;

   // decode one raw byte against the current state
   always_comb begin
      sec_len  = sector_bytes(size_ff);
      cnt_inc  = cnt_ff + CNT_W'(1);
      fit_sum  = {1'b0, pos_ff} + (TOT_W+1)'(sec_len);
      off_sum  = {1'b0, pos_ff} + (TOT_W+1)'(cnt_ff);
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      trk_in   = trk_ff;
      side_in  = side_ff;
      sec_in   = sec_ff;
      size_in  = size_ff;
      pos_in   = pos_ff;
      nsec_in  = nsec_ff;
      err_in   = err_ff;
      fits_in  = fits_ff;
      has_res  = 1'b0;
      res_kind = KIND_DATA;
      res_data = 8'd0;
      res_off  = '0;
      case (phase_ff)
         PH_SCAN: begin
            if (in_byte_ff == MARK_ID) begin
               phase_in = PH_HEADER;
               cnt_in   = '0;
            end else if (in_byte_ff == MARK_DATA) begin
               fits_in  = (fit_sum <= CAP);
               phase_in = PH_DATA;
               cnt_in   = '0;
            end
         end
         PH_HEADER: begin
            case (cnt_ff[1:0])
               2'd0: begin
                  trk_in = in_byte_ff;
                  cnt_in = CNT_W'(1);
               end
               2'd1: begin
                  side_in = in_byte_ff;
                  cnt_in  = CNT_W'(2);
               end
               2'd2: begin
                  sec_in = in_byte_ff;
                  cnt_in = CNT_W'(3);
               end
               default: begin
                  if (in_byte_ff >= 8'(SIZE_CODES)) begin
                     err_in   = ST_BAD_SIZE;
                     phase_in = PH_FROZEN;
                  end else begin
                     size_in  = in_byte_ff[1:0];
                     phase_in = PH_HDR_CRC;
                  end
               end
            endcase
         end
         PH_HDR_CRC: begin
            if (in_byte_ff != MARK_CRC) begin
               err_in   = ST_NO_HCRC;
               phase_in = PH_FROZEN;
            end else begin
               cnt_in   = CNT_W'(HDR_TAIL_SKIP);
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
            if (cnt_ff <= CNT_W'(1)) begin
               phase_in = PH_SCAN;
            end
         end
         PH_DATA: begin
            if (fits_ff) begin
               has_res  = 1'b1;
               res_kind = KIND_DATA;
               res_data = in_byte_ff;
               res_off  = off_sum[OFF_W-1:0];
            end
            cnt_in = cnt_inc;
            if (cnt_inc >= sec_len) begin
               phase_in = PH_DATA_CRC;
            end
         end
         PH_DATA_CRC: begin
            if (in_byte_ff != MARK_CRC) begin
               err_in   = ST_NO_DCRC;
               phase_in = PH_FROZEN;
            end else if (!fits_ff) begin
               err_in   = ST_NO_SPACE;
               phase_in = PH_FROZEN;
            end else begin
               pos_in   = fit_sum[TOT_W-1:0];
               nsec_in  = nsec_ff + 7'd1;
               has_res  = 1'b1;
               res_kind = KIND_SECTOR;
               cnt_in   = CNT_W'(DATA_TAIL_SKIP);
               phase_in = PH_SKIP;
            end
         end
         default: begin
            phase_in = PH_FROZEN;
         end
      endcase

      // build results from the updated state
      r_first.kind   = res_kind;
      r_first.data   = res_data;
      r_first.offset = res_off;
      r_first.trk    = trk_in;
      r_first.side   = side_in;
      r_first.sec    = sec_in;
      r_first.size   = size_in;
      r_first.count  = nsec_in;
      r_first.total  = pos_in;
      r_first.status = ST_OK;
      r_first.last   = !in_eot_ff;
      r_stat         = r_first;
      r_stat.kind    = KIND_STATUS;
      r_stat.data    = 8'd0;
      r_stat.offset  = '0;
      r_stat.status  = err_in;
      r_stat.last    = 1'b1;

      // end of track: restart for the next track
      if (in_eot_ff) begin
         phase_in = PH_SCAN;
         cnt_in   = '0;
         trk_in   = 8'd0;
         side_in  = 8'd0;
         sec_in   = 8'd0;
         size_in  = 2'd0;
         pos_in   = '0;
         nsec_in  = 7'd0;
         err_in   = ST_OK;
         fits_in  = 1'b0;
      end
   end

   // input register and result buffer control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end

      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      fill_in  = fill_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         fill_in  = fill_ff - 2'd1;
      end
      if (process) begin
         if (has_res) begin
            slot0_in = r_first;
            slot1_in = r_stat;
            fill_in  = in_eot_ff ? 2'd2 : 2'd1;
         end else if (in_eot_ff) begin
            slot0_in = r_stat;
            fill_in  = 2'd1;
         end else begin
            fill_in  = (fill_ff == 2'd1) ? 2'd0 : fill_ff;
            if (pop) begin
               fill_in = fill_ff - 2'd1;
            end
         end
      end
   end

   // hold state, input register and result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fill_ff     <= 2'd0;
         phase_ff    <= PH_SCAN;
         cnt_ff      <= '0;
         trk_ff      <= 8'd0;
         side_ff     <= 8'd0;
         sec_ff      <= 8'd0;
         size_ff     <= 2'd0;
         pos_ff      <= '0;
         nsec_ff     <= 7'd0;
         err_ff      <= ST_OK;
         fits_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         fill_ff     <= fill_in;
         if (process) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            trk_ff   <= trk_in;
            side_ff  <= side_in;
            sec_ff   <= sec_in;
            size_ff  <= size_in;
            pos_ff   <= pos_in;
            nsec_ff  <= nsec_in;
            err_ff   <= err_in;
            fits_ff  <= fits_in;
         end
      end
      if (accept) begin
         in_byte_ff <= req_raw_byte;
         in_eot_ff  <= req_end_of_track;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // drive result port from the head of the buffer
   assign rsp_valid        = (fill_ff != 2'd0);
   assign rsp_kind         = slot0_ff.kind;
   assign rsp_data_byte    = slot0_ff.data;
   assign rsp_write_offset = slot0_ff.offset;
   assign rsp_id_track     = slot0_ff.trk;
   assign rsp_id_side      = slot0_ff.side;
   assign rsp_id_sector    = slot0_ff.sec;
   assign rsp_size_code    = slot0_ff.size;
   assign rsp_sector_count = slot0_ff.count;
   assign rsp_data_total   = slot0_ff.total;
   assign rsp_status       = slot0_ff.status;
   assign rsp_last         = slot0_ff.last;

   // buffer never holds more than two results
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("result buffer overfilled");

   // with two results queued, the head is never the last of its byte
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) |-> (!slot0_ff.last && slot1_ff.last))
      else $error("result pair out of order");

   // a nonzero status only travels on a track end result
   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_kind == KIND_STATUS))
      else $error("status on a non-status result");

   // end of track restarts the decoder
   a_eot_clear: assert property (@(posedge clock) disable iff (reset)
      (process && in_eot_ff) |=> (phase_ff == PH_SCAN && pos_ff == '0
                                  && err_ff == ST_OK))
      else $error("decoder not cleared after end of track");

   // input register is never overwritten while still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load_ok) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("pending raw byte lost");

endmodule

`default_nettype wire
